>>> rtl/core/scx_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment / circle crossing: shared constants
// Chunk size of the pipelined multipliers, used for their stage count.
// ----------------------------------------------------------------------------
package scx_pkg;

  // Bits of the second operand consumed per multiplier stage
  localparam int MUL_CHUNK = 16;

endpackage
`default_nettype wire

>>> rtl/core/scx_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment / circle crossing: channel interfaces
// Valid/ready channels for the segment item and the crossing item.
// ----------------------------------------------------------------------------
interface scx_seg_if #(parameter int COORD_WIDTH = 24);
  logic                          valid;
  logic                          ready;
  logic signed [COORD_WIDTH-1:0] seg_start_x;
  logic signed [COORD_WIDTH-1:0] seg_start_y;
  logic signed [COORD_WIDTH-1:0] seg_end_x;
  logic signed [COORD_WIDTH-1:0] seg_end_y;
  logic signed [COORD_WIDTH-1:0] center_x;
  logic signed [COORD_WIDTH-1:0] center_y;
  logic        [COORD_WIDTH-2:0] circle_radius;

  modport source (output valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                  center_x, center_y, circle_radius, input ready);
  modport sink (input valid, seg_start_x, seg_start_y, seg_end_x, seg_end_y,
                center_x, center_y, circle_radius, output ready);
endinterface

interface scx_hit_if #(parameter int COORD_WIDTH = 24);
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic signed [COORD_WIDTH-1:0] hit_x;
  logic signed [COORD_WIDTH-1:0] hit_y;

  modport source (output valid, found, hit_x, hit_y, input ready);
  modport sink (input valid, found, hit_x, hit_y, output ready);
endinterface
`default_nettype wire

>>> rtl/core/scx_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment / circle crossing: pipelined signed multiplier
// Consumes one chunk of b per stage and accumulates the shifted partial product.
// ----------------------------------------------------------------------------
module scx_mul import scx_pkg::*; #(
  parameter int AW = 25,
  parameter int BW = 25
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [AW-1:0]    a,
  input  logic signed [BW-1:0]    b,
  output logic signed [AW+BW-1:0] p
);

  localparam int NC = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int BX = NC * MUL_CHUNK;
  localparam int PW = AW + BW;

  logic signed [AW-1:0] a_q [NC];
  logic signed [BX-1:0] b_q [NC];
  logic signed [PW-1:0] acc [NC];

  for (genvar j = 0; j < NC; j++) begin : g_stage
    logic signed [AW-1:0]          a_in;
    logic signed [BX-1:0]          b_in;
    logic signed [PW-1:0]          acc_in;
    logic signed [MUL_CHUNK:0]     chunk;
    logic signed [AW+MUL_CHUNK:0]  prod;

    if (j == 0) begin : g_first
      assign a_in   = a;
      assign b_in   = BX'(b);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in   = a_q[j-1];
      assign b_in   = b_q[j-1];
      assign acc_in = acc[j-1];
    end

    // lower chunks are unsigned, the top chunk carries the sign
    if (j == NC - 1) begin : g_top
      assign chunk = signed'({b_in[BX-1], b_in[j*MUL_CHUNK +: MUL_CHUNK]});
    end else begin : g_low
      assign chunk = signed'({1'b0, b_in[j*MUL_CHUNK +: MUL_CHUNK]});
    end

    assign prod = a_in * chunk;

    always_ff @(posedge clk) begin
      if (en) begin
        a_q[j] <= a_in;
        b_q[j] <= b_in;
        acc[j] <= acc_in + (PW'(prod) <<< (j * MUL_CHUNK));
      end
    end
  end

  assign p = acc[NC-1];

endmodule
`default_nettype wire

>>> rtl/core/scx_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment / circle crossing: pipelined floor divider
// Signed numerator over a positive divisor, one quotient bit per stage,
// rounded toward minus infinity in the last stage.
// ----------------------------------------------------------------------------
module scx_div #(
  parameter int NW = 78,
  parameter int DW = 49,
  parameter int QB = 25
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic        [DW-1:0] den,
  output logic signed [QB+1:0] quo
);

  localparam int TW = DW + QB;

  logic [NW-1:0] mag;
  logic [TW-1:0] rm  [QB+1];
  logic [QB-1:0] qv  [QB+1];
  logic [DW-1:0] dq  [QB+1];
  logic          ng  [QB+1];
  logic signed [QB+1:0] qs;

  assign mag = num[NW-1] ? NW'(-num) : NW'(num);

  always_ff @(posedge clk) begin
    if (en) begin
      rm[0] <= mag[TW-1:0];
      qv[0] <= '0;
      dq[0] <= den;
      ng[0] <= num[NW-1];
    end
  end

  for (genvar i = 1; i <= QB; i++) begin : g_step
    localparam int BitPos = QB - i;
    logic [TW-1:0] sh;
    logic          ge;

    assign sh = TW'(dq[i-1]) << BitPos;
    assign ge = rm[i-1] >= sh;

    always_ff @(posedge clk) begin
      if (en) begin
        rm[i] <= ge ? rm[i-1] - sh : rm[i-1];
        qv[i] <= ge ? (qv[i-1] | (QB'(1) << BitPos)) : qv[i-1];
        dq[i] <= dq[i-1];
        ng[i] <= ng[i-1];
      end
    end
  end

  assign qs = signed'({2'b00, qv[QB]});

  // negative numerator: negate and step down when a remainder is left
  always_ff @(posedge clk) begin
    if (en) begin
      quo <= ng[QB] ? (-qs - (QB+2)'(rm[QB] != '0)) : qs;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/segment_circle_intersection.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Segment / circle crossing
// Translates the segment to the circle center, takes the discriminant, its
// root and the two crossings, keeps those in the segment's box and reports
// the one nearer the segment end.
// ----------------------------------------------------------------------------
// Stages: from item accept to result valid the item passes the chunked multiplier
//   stages (ten at COORD_WIDTH = 24), the 2*COORD_WIDTH root stages and the
//   COORD_WIDTH + 3 divider stages.
// Throughput: one item per cycle; a stalled output freezes the whole pipe.
// Reset: synchronous rst clears the valid bits only; the data registers are not reset.
module segment_circle_intersection import scx_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic       clk,
  input  logic       rst,
  scx_seg_if.sink    seg,
  scx_hit_if.source  hit
);

  localparam int W    = COORD_WIDTH;
  localparam int DDW  = 2 * W + 3;
  localparam int PW1  = 2 * W + 2;
  localparam int PW2  = 2 * DDW;
  localparam int BW3  = W + 2;
  localparam int PW3  = DDW + BW3;
  localparam int NW   = PW3 + 1;
  localparam int QB   = W + 1;
  localparam int QW   = QB + 2;
  localparam int XW   = W + 4;
  localparam int EW   = XW + 1;
  localparam int PW4  = 2 * EW;
  localparam int SQ   = 2 * W;
  localparam int RW   = 4 * W + 1;
  localparam int Lat1 = (W + 1 + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int Lat2 = (DDW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int Lat3 = (BW3 + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int Lat4 = (EW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int PC   = 2 + Lat1;
  localparam int PD   = PC + Lat2 + 1;
  localparam int PQ   = PD + SQ;
  localparam int PE   = PQ + Lat3 + 1;
  localparam int PF   = PE + QB + 3;
  localparam int PG   = PF + 1;
  localparam int PH   = PG + Lat4 + 1;
  localparam int PO   = PH + 1;
  localparam int NS   = PO + 1;

  typedef struct packed {
    logic signed [W-1:0]   x1;
    logic signed [W-1:0]   y1;
    logic signed [W-1:0]   x2;
    logic signed [W-1:0]   y2;
    logic signed [W-1:0]   cx;
    logic signed [W-1:0]   cy;
    logic        [W-2:0]   r;
    logic signed [W:0]     dx;
    logic signed [W:0]     dy;
    logic signed [W:0]     ax;
    logic signed [W:0]     ay;
    logic signed [W:0]     bx;
    logic signed [W:0]     by;
    logic signed [DDW-1:0] dr2;
    logic signed [DDW-1:0] dd;
    logic signed [DDW-1:0] r2;
    logic                  bad;
    logic signed [XW-1:0]  sx1;
    logic signed [XW-1:0]  sy1;
    logic signed [XW-1:0]  sx2;
    logic signed [XW-1:0]  sy2;
    logic                  v1;
    logic                  v2;
  } side_t;

  logic              en;
  logic [NS-1:0]     vld;
  side_t             sd    [NS];
  side_t             sd_nx [NS];

  logic signed [PW1-1:0] p_dx2, p_dy2, p_ab, p_ba, p_rr;
  logic signed [PW2-1:0] p_rd, p_dd2;
  logic signed [PW3-1:0] p_dxq, p_dyq, p_ddy, p_ddx;
  logic signed [PW4-1:0] p_ex1, p_ey1, p_ex2, p_ey2;
  logic signed [DDW-1:0] dr2_c, dd_c;
  logic signed [PW2-1:0] disc_c, disc_q;
  logic signed [BW3-1:0] ady_c;
  logic signed [NW-1:0]  sdxq_c;
  logic signed [NW-1:0]  nx1_q, nx2_q, ny1_q, ny2_q;
  logic signed [QW-1:0]  qx1, qx2, qy1, qy2;
  logic signed [XW-1:0]  sx1_q, sy1_q, sx2_q, sy2_q;
  logic signed [W-1:0]   xl, xh, yl, yh;
  logic                  v1_c, v2_c;
  logic signed [EW-1:0]  ex1_q, ey1_q, ex2_q, ey2_q;
  logic signed [PW4:0]   d1_q, d2_q;
  logic                  pick1, found_c;
  logic                  found_q;
  logic signed [W-1:0]   hx_q, hy_q;

  // A stalled result freezes every stage, so nothing is lost or repeated.
  assign en        = !vld[NS-1] || hit.ready;
  assign seg.ready = en;

  // ---------------- side line ----------------
  assign dr2_c = DDW'(p_dx2) + DDW'(p_dy2);
  assign dd_c  = DDW'(p_ab) - DDW'(p_ba);
  assign disc_c = p_rd - p_dd2;

  always_comb begin
    xl = (sd[PG-1].x1 < sd[PG-1].x2) ? sd[PG-1].x1 : sd[PG-1].x2;
    xh = (sd[PG-1].x1 < sd[PG-1].x2) ? sd[PG-1].x2 : sd[PG-1].x1;
    yl = (sd[PG-1].y1 < sd[PG-1].y2) ? sd[PG-1].y1 : sd[PG-1].y2;
    yh = (sd[PG-1].y1 < sd[PG-1].y2) ? sd[PG-1].y2 : sd[PG-1].y1;
    v1_c = (sx1_q >= XW'(xl)) && (sx1_q <= XW'(xh)) &&
           (sy1_q >= XW'(yl)) && (sy1_q <= XW'(yh));
    v2_c = (sx2_q >= XW'(xl)) && (sx2_q <= XW'(xh)) &&
           (sy2_q >= XW'(yl)) && (sy2_q <= XW'(yh));
  end

  always_comb begin
    sd_nx[0]    = '0;
    sd_nx[0].x1 = seg.seg_start_x;
    sd_nx[0].y1 = seg.seg_start_y;
    sd_nx[0].x2 = seg.seg_end_x;
    sd_nx[0].y2 = seg.seg_end_y;
    sd_nx[0].cx = seg.center_x;
    sd_nx[0].cy = seg.center_y;
    sd_nx[0].r  = seg.circle_radius;
    for (int k = 1; k < NS; k++) begin
      sd_nx[k] = sd[k-1];
    end
    // translate to the circle center
    sd_nx[1].dx = (W+1)'(sd[0].x2) - (W+1)'(sd[0].x1);
    sd_nx[1].dy = (W+1)'(sd[0].y2) - (W+1)'(sd[0].y1);
    sd_nx[1].ax = (W+1)'(sd[0].x1) - (W+1)'(sd[0].cx);
    sd_nx[1].ay = (W+1)'(sd[0].y1) - (W+1)'(sd[0].cy);
    sd_nx[1].bx = (W+1)'(sd[0].x2) - (W+1)'(sd[0].cx);
    sd_nx[1].by = (W+1)'(sd[0].y2) - (W+1)'(sd[0].cy);
    sd_nx[PC].dr2 = dr2_c;
    sd_nx[PC].dd  = dd_c;
    sd_nx[PC].r2  = DDW'(p_rr);
    sd_nx[PC].bad = (dr2_c == '0);
    sd_nx[PD].bad = sd[PD-1].bad | disc_c[PW2-1];
    sd_nx[PG].sx1 = sx1_q;
    sd_nx[PG].sy1 = sy1_q;
    sd_nx[PG].sx2 = sx2_q;
    sd_nx[PG].sy2 = sy2_q;
    sd_nx[PG].v1  = v1_c;
    sd_nx[PG].v2  = v2_c;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-2:0], seg.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        sd[k] <= sd_nx[k];
      end
    end
  end

  // ---------------- squares and cross product ----------------
  scx_mul #(.AW(W+1), .BW(W+1)) u_mul_dx2 (
    .clk(clk), .en(en), .a(sd[1].dx), .b(sd[1].dx), .p(p_dx2));
  scx_mul #(.AW(W+1), .BW(W+1)) u_mul_dy2 (
    .clk(clk), .en(en), .a(sd[1].dy), .b(sd[1].dy), .p(p_dy2));
  scx_mul #(.AW(W+1), .BW(W+1)) u_mul_ab (
    .clk(clk), .en(en), .a(sd[1].ax), .b(sd[1].by), .p(p_ab));
  scx_mul #(.AW(W+1), .BW(W+1)) u_mul_ba (
    .clk(clk), .en(en), .a(sd[1].bx), .b(sd[1].ay), .p(p_ba));
  scx_mul #(.AW(W+1), .BW(W+1)) u_mul_rr (
    .clk(clk), .en(en), .a(signed'({2'b00, sd[1].r})), .b(signed'({2'b00, sd[1].r})),
    .p(p_rr));

  // ---------------- discriminant ----------------
  scx_mul #(.AW(DDW), .BW(DDW)) u_mul_rd (
    .clk(clk), .en(en), .a(sd[PC].r2), .b(sd[PC].dr2), .p(p_rd));
  scx_mul #(.AW(DDW), .BW(DDW)) u_mul_dd2 (
    .clk(clk), .en(en), .a(sd[PC].dd), .b(sd[PC].dd), .p(p_dd2));

  always_ff @(posedge clk) begin
    if (en) begin
      disc_q <= disc_c;
    end
  end

  // ---------------- square root, one result bit per stage ----------------
  logic [RW-1:0] srm [SQ];
  logic [SQ-1:0] srt [SQ];

  for (genvar i = 0; i < SQ; i++) begin : g_sqrt
    localparam int BitPos = SQ - 1 - i;
    logic [RW-1:0] rm_in;
    logic [RW-1:0] trial;
    logic [SQ-1:0] rt_in;
    logic          ge;

    if (i == 0) begin : g_first
      assign rm_in = RW'(disc_q[4*W-1:0]);
      assign rt_in = '0;
    end else begin : g_next
      assign rm_in = srm[i-1];
      assign rt_in = srt[i-1];
    end

    // (root + 2^b)^2 - root^2, the two terms never overlap
    assign trial = (RW'(rt_in) << (BitPos + 1)) | (RW'(1) << (2 * BitPos));
    assign ge    = rm_in >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        srm[i] <= ge ? rm_in - trial : rm_in;
        srt[i] <= ge ? (rt_in | (SQ'(1) << BitPos)) : rt_in;
      end
    end
  end

  // ---------------- numerators ----------------
  assign ady_c = sd[PQ].dy[W] ? -BW3'(sd[PQ].dy) : BW3'(sd[PQ].dy);

  scx_mul #(.AW(DDW), .BW(BW3)) u_mul_dxq (
    .clk(clk), .en(en), .a(signed'(DDW'(srt[SQ-1]))), .b(BW3'(sd[PQ].dx)), .p(p_dxq));
  scx_mul #(.AW(DDW), .BW(BW3)) u_mul_dyq (
    .clk(clk), .en(en), .a(signed'(DDW'(srt[SQ-1]))), .b(ady_c), .p(p_dyq));
  scx_mul #(.AW(DDW), .BW(BW3)) u_mul_ddy (
    .clk(clk), .en(en), .a(sd[PQ].dd), .b(BW3'(sd[PQ].dy)), .p(p_ddy));
  scx_mul #(.AW(DDW), .BW(BW3)) u_mul_ddx (
    .clk(clk), .en(en), .a(sd[PQ].dd), .b(BW3'(sd[PQ].dx)), .p(p_ddx));

  // sign of dy counts zero as positive
  assign sdxq_c = sd[PE-1].dy[W] ? -NW'(p_dxq) : NW'(p_dxq);

  always_ff @(posedge clk) begin
    if (en) begin
      nx1_q <= NW'(p_ddy) + sdxq_c;
      nx2_q <= NW'(p_ddy) - sdxq_c;
      ny1_q <= NW'(p_dyq) - NW'(p_ddx);
      ny2_q <= -NW'(p_ddx) - NW'(p_dyq);
    end
  end

  // ---------------- divide by the squared length ----------------
  scx_div #(.NW(NW), .DW(2*W+1), .QB(QB)) u_div_x1 (
    .clk(clk), .en(en), .num(nx1_q), .den(sd[PE].dr2[2*W:0]), .quo(qx1));
  scx_div #(.NW(NW), .DW(2*W+1), .QB(QB)) u_div_x2 (
    .clk(clk), .en(en), .num(nx2_q), .den(sd[PE].dr2[2*W:0]), .quo(qx2));
  scx_div #(.NW(NW), .DW(2*W+1), .QB(QB)) u_div_y1 (
    .clk(clk), .en(en), .num(ny1_q), .den(sd[PE].dr2[2*W:0]), .quo(qy1));
  scx_div #(.NW(NW), .DW(2*W+1), .QB(QB)) u_div_y2 (
    .clk(clk), .en(en), .num(ny2_q), .den(sd[PE].dr2[2*W:0]), .quo(qy2));

  always_ff @(posedge clk) begin
    if (en) begin
      sx1_q <= XW'(qx1) + XW'(sd[PF-1].cx);
      sx2_q <= XW'(qx2) + XW'(sd[PF-1].cx);
      sy1_q <= XW'(qy1) + XW'(sd[PF-1].cy);
      sy2_q <= XW'(qy2) + XW'(sd[PF-1].cy);
      ex1_q <= EW'(sx1_q) - EW'(sd[PF].x2);
      ey1_q <= EW'(sy1_q) - EW'(sd[PF].y2);
      ex2_q <= EW'(sx2_q) - EW'(sd[PF].x2);
      ey2_q <= EW'(sy2_q) - EW'(sd[PF].y2);
    end
  end

  // ---------------- distance to the segment end ----------------
  scx_mul #(.AW(EW), .BW(EW)) u_mul_ex1 (
    .clk(clk), .en(en), .a(ex1_q), .b(ex1_q), .p(p_ex1));
  scx_mul #(.AW(EW), .BW(EW)) u_mul_ey1 (
    .clk(clk), .en(en), .a(ey1_q), .b(ey1_q), .p(p_ey1));
  scx_mul #(.AW(EW), .BW(EW)) u_mul_ex2 (
    .clk(clk), .en(en), .a(ex2_q), .b(ex2_q), .p(p_ex2));
  scx_mul #(.AW(EW), .BW(EW)) u_mul_ey2 (
    .clk(clk), .en(en), .a(ey2_q), .b(ey2_q), .p(p_ey2));

  always_ff @(posedge clk) begin
    if (en) begin
      d1_q <= (PW4+1)'(p_ex1) + (PW4+1)'(p_ey1);
      d2_q <= (PW4+1)'(p_ex2) + (PW4+1)'(p_ey2);
    end
  end

  // ---------------- select and output register ----------------
  // equal distances go to the second root
  assign pick1   = (sd[PH].v1 && sd[PH].v2) ? (d1_q < d2_q) : sd[PH].v1;
  assign found_c = !sd[PH].bad && (sd[PH].v1 || sd[PH].v2);

  always_ff @(posedge clk) begin
    if (en) begin
      found_q <= found_c;
      if (!found_c) begin
        hx_q <= '0;
        hy_q <= '0;
      end else if (pick1) begin
        hx_q <= sd[PH].sx1[W-1:0];
        hy_q <= sd[PH].sy1[W-1:0];
      end else begin
        hx_q <= sd[PH].sx2[W-1:0];
        hy_q <= sd[PH].sy2[W-1:0];
      end
    end
  end

  assign hit.valid = vld[NS-1];
  assign hit.found = found_q;
  assign hit.hit_x = hx_q;
  assign hit.hit_y = hy_q;

  // ---------------- assertions ----------------
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    hit.valid && !hit.found |-> hit.hit_x == '0 && hit.hit_y == '0)
    else $error("miss item carries a nonzero crossing");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> vld == $past(vld))
    else $error("pipeline moved while stalled");

  a_take: assert property (@(posedge clk) disable iff (rst)
    seg.valid && seg.ready |=> vld[0])
    else $error("accepted item not captured");

  a_drain: assert property (@(posedge clk) disable iff (rst)
    hit.valid && hit.ready && !vld[NS-2] |=> !hit.valid)
    else $error("result repeated after delivery");

endmodule
`default_nettype wire

>>> test/tb_segment_circle_intersection.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Segment / circle crossing testbench
// Drives segment items through a valid/ready channel with bursty gaps and
// checks every crossing item against an exact wide-integer predictor,
// or a typed expectation. Directed rows cover zero-length segments, misses,
// tangents and extremes. Random items then follow, and the receiver stalls
// in random patterns with one long hold-off so that the pipe fills up.
// ----------------------------------------------------------------------------
module tb_segment_circle_intersection;
  import scx_pkg::*;

  localparam int CW         = 24;
  localparam int N_RANDOM   = 430;
  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN      = 150;

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic signed [CW-1:0] sx, sy, ex, ey, cx, cy;
    logic        [CW-2:0] rad;
  } seg_item_t;

  typedef struct {
    logic                 found;
    logic signed [CW-1:0] x, y;
  } crossing_t;

  typedef struct {
    seg_item_t item;
    logic      typed;
    crossing_t want;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  scx_seg_if #(.COORD_WIDTH(CW)) seg_ch ();
  scx_hit_if #(.COORD_WIDTH(CW)) hit_ch ();

  segment_circle_intersection #(.COORD_WIDTH(CW)) DUT (
    .clk (clk),
    .rst (rst),
    .seg (seg_ch),
    .hit (hit_ch)
  );

  always #1 clk = ~clk;

  crossing_t pending_hits[$];
  int        n_errors  = 0;
  int        idle_cnt  = 0;
  bit        sending   = 1'b1;

  // floor division, divisor positive
  function automatic wide_t floor_div(wide_t n, wide_t d);
    wide_t q;
    q = n / d;
    if (n < 0 && (n % d) != 0) q = q - 1;
    return q;
  endfunction

  function automatic bit in_box(wide_t x, wide_t y, wide_t x1, wide_t y1,
                                wide_t x2, wide_t y2);
    wide_t xl, xh, yl, yh;
    xl = (x1 < x2) ? x1 : x2;
    xh = (x1 < x2) ? x2 : x1;
    yl = (y1 < y2) ? y1 : y2;
    yh = (y1 < y2) ? y2 : y1;
    return x >= xl && x <= xh && y >= yl && y <= yh;
  endfunction

  function automatic crossing_t predict_crossing(seg_item_t it);
    wide_t x1, y1, x2, y2, cx, cy, rr, dx, dy, dr2, dd, disc, q, cand, one;
    wide_t sdq, adq, ndy, ndx, px1, px2, py1, py2, d1, d2;
    bit v1, v2, pick1;
    crossing_t res;
    res.found = 1'b0; res.x = '0; res.y = '0;
    x1 = wide_t'(it.sx); y1 = wide_t'(it.sy);
    x2 = wide_t'(it.ex); y2 = wide_t'(it.ey);
    cx = wide_t'(it.cx); cy = wide_t'(it.cy);
    rr = wide_t'({1'b0, it.rad});
    dx = x2 - x1;
    dy = y2 - y1;
    dr2 = dx * dx + dy * dy;
    if (dr2 == '0) return res;
    dd = (x1 - cx) * (y2 - cy) - (x2 - cx) * (y1 - cy);
    disc = rr * rr * dr2 - dd * dd;
    if (disc < 0) return res;
    one = wide_t'(1);
    q = '0;
    for (int i = 2 * CW + 1; i >= 0; i--) begin
      cand = q | (one << i);
      if (cand * cand <= disc) q = cand;
    end
    // sgn(0) counts as +1
    sdq = (dy < 0) ? -(dx * q) : dx * q;
    adq = ((dy < 0) ? -dy : dy) * q;
    ndy = dd * dy;
    ndx = -(dd * dx);
    px1 = floor_div(ndy + sdq, dr2) + cx;
    px2 = floor_div(ndy - sdq, dr2) + cx;
    py1 = floor_div(ndx + adq, dr2) + cy;
    py2 = floor_div(ndx - adq, dr2) + cy;
    v1 = in_box(px1, py1, x1, y1, x2, y2);
    v2 = in_box(px2, py2, x1, y1, x2, y2);
    if (!v1 && !v2) return res;
    if (v1 && v2) begin
      d1 = (px1 - x2) * (px1 - x2) + (py1 - y2) * (py1 - y2);
      d2 = (px2 - x2) * (px2 - x2) + (py2 - y2) * (py2 - y2);
      pick1 = d1 < d2;
    end else begin
      pick1 = v1;
    end
    res.found = 1'b1;
    res.x = pick1 ? px1[CW-1:0] : px2[CW-1:0];
    res.y = pick1 ? py1[CW-1:0] : py2[CW-1:0];
    return res;
  endfunction

  // Offer one item and hold it until accepted; gap afterwards if asked.
  task automatic send_segment(seg_item_t it, bit typed, crossing_t want, int gap);
    seg_ch.valid         <= 1'b1;
    seg_ch.seg_start_x   <= it.sx;
    seg_ch.seg_start_y   <= it.sy;
    seg_ch.seg_end_x     <= it.ex;
    seg_ch.seg_end_y     <= it.ey;
    seg_ch.center_x      <= it.cx;
    seg_ch.center_y      <= it.cy;
    seg_ch.circle_radius <= it.rad;
    @(posedge clk);
    while (!seg_ch.ready) @(posedge clk);
    pending_hits.push_back(typed ? want : predict_crossing(it));
    if (gap > 0) begin
      seg_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic seg_item_t random_segment();
    seg_item_t it;
    int kind, span;
    kind = $urandom_range(0, 9);
    if (kind < 2) begin
      // noise over the full field ranges
      it.sx = CW'($urandom); it.sy = CW'($urandom);
      it.ex = CW'($urandom); it.ey = CW'($urandom);
      it.cx = CW'($urandom); it.cy = CW'($urandom);
      it.rad = (CW-1)'($urandom);
    end else begin
      // segment near a circle so that crossings are likely
      it.cx  = CW'($signed($urandom_range(0, 2**21)) - 2**20);
      it.cy  = CW'($signed($urandom_range(0, 2**21)) - 2**20);
      span   = (kind == 9) ? 2**20 : 2**$urandom_range(2, 16);
      it.rad = (CW-1)'($urandom_range(1, span));
      it.sx  = CW'(it.cx + $signed($urandom_range(0, 4 * span)) - 2 * span);
      it.sy  = CW'(it.cy + $signed($urandom_range(0, 4 * span)) - 2 * span);
      it.ex  = CW'(it.cx + $signed($urandom_range(0, 4 * span)) - 2 * span);
      it.ey  = CW'(it.cy + $signed($urandom_range(0, 4 * span)) - 2 * span);
      case ($urandom_range(0, 7))
        0: it.ey = it.sy;
        1: it.ex = it.sx;
        2: begin it.ex = it.sx; it.ey = it.sy; end
        default: ;
      endcase
    end
    return it;
  endfunction

  stim_row_t directed[$];

  function automatic stim_row_t mk_row(int sx, int sy, int ex, int ey, int cx, int cy,
                                      int rad, bit typed, bit f, int hx, int hy);
    stim_row_t r;
    r.item.sx = CW'(sx); r.item.sy = CW'(sy); r.item.ex = CW'(ex); r.item.ey = CW'(ey);
    r.item.cx = CW'(cx); r.item.cy = CW'(cy); r.item.rad = (CW-1)'(rad);
    r.typed = typed;
    r.want.found = f; r.want.x = CW'(hx); r.want.y = CW'(hy);
    return r;
  endfunction

  initial begin
    int gap, burst;
    seg_item_t it;
    crossing_t none;
    none.found = 1'b0; none.x = '0; none.y = '0;

    seg_ch.valid         <= 1'b0;
    seg_ch.seg_start_x   <= '0;
    seg_ch.seg_start_y   <= '0;
    seg_ch.seg_end_x     <= '0;
    seg_ch.seg_end_y     <= '0;
    seg_ch.center_x      <= '0;
    seg_ch.center_y      <= '0;
    seg_ch.circle_radius <= '0;

    // zero-length segments
    directed.push_back(mk_row(0, 0, 0, 0, 0, 0, 256, 1, 0, 0, 0));
    directed.push_back(mk_row(8388607, 8388607, 8388607, 8388607, -8388608, -8388608,
                              8388607, 1, 0, 0, 0));
    // negative discriminant: circle far away
    directed.push_back(mk_row(0, 0, 256, 0, 0, 100000, 256, 1, 0, 0, 0));
    // both crossings valid, the one nearer the end wins
    directed.push_back(mk_row(-1024, 0, 1024, 0, 0, 0, 512, 1, 1, 512, 0));
    // segment wholly inside the circle: no crossing in box
    directed.push_back(mk_row(0, 0, 10, 0, 0, 0, 1000, 1, 0, 0, 0));
    // zero radius
    directed.push_back(mk_row(-100, 0, 100, 0, 0, 0, 0, 0, 0, 0, 0));
    // tangent lines
    directed.push_back(mk_row(-1024, 512, 1024, 512, 0, 0, 512, 0, 0, 0, 0));
    directed.push_back(mk_row(512, -1024, 512, 1024, 0, 0, 512, 0, 0, 0, 0));
    // vertical, reversed and diagonal segments
    directed.push_back(mk_row(0, 1024, 0, -1024, 0, 0, 300, 0, 0, 0, 0));
    directed.push_back(mk_row(1024, 0, -1024, 0, 0, 0, 300, 0, 0, 0, 0));
    directed.push_back(mk_row(-777, -901, 1203, 655, 17, -33, 640, 0, 0, 0, 0));
    directed.push_back(mk_row(-777, 901, 1203, -655, 17, -33, 640, 0, 0, 0, 0));
    // only one crossing on the segment
    directed.push_back(mk_row(0, 0, 2000, 0, 0, 0, 1000, 0, 0, 0, 0));
    // extreme coordinates and radius
    directed.push_back(mk_row(-8388608, -8388608, 8388607, 8388607, 0, 0, 8388607,
                              0, 0, 0, 0));
    directed.push_back(mk_row(-8388608, 8388607, 8388607, -8388608, 8388607, 8388607,
                              8388607, 0, 0, 0, 0));
    directed.push_back(mk_row(8388607, -8388608, -8388608, 8388607, -8388608, 0,
                              4194304, 0, 0, 0, 0));
    directed.push_back(mk_row(-8388608, 0, 8388607, 0, 0, 0, 1, 0, 0, 0, 0));
    directed.push_back(mk_row(0, -8388608, 0, 8388607, 0, 0, 8388607, 0, 0, 0, 0));
    directed.push_back(mk_row(-1, -1, 1, 1, 0, 0, 1, 0, 0, 0, 0));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i])
      send_segment(directed[i].item, directed[i].typed, directed[i].want,
                   $urandom_range(0, 2));

    burst = 0;
    for (int n = 0; n < N_RANDOM; n++) begin
      it = random_segment();
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end
      burst--;
      send_segment(it, 1'b0, none, (burst == 0) ? gap : 0);
    end
    seg_ch.valid <= 1'b0;
    sending = 1'b0;

    while (pending_hits.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (n_errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // receiver: stall patterns that change every so often, one long hold-off
  initial begin
    int mode, held;
    hit_ch.ready <= 1'b0;
    held = 0;
    @(negedge rst);
    while (1) begin
      mode = $urandom_range(0, 3);
      repeat ($urandom_range(16, 96)) begin
        @(posedge clk);
        case (mode)
          0: hit_ch.ready <= 1'b1;
          1: hit_ch.ready <= ($urandom_range(0, 3) != 0);
          2: hit_ch.ready <= ($urandom_range(0, 1) != 0);
          default: hit_ch.ready <= ($urandom_range(0, 4) == 0);
        endcase
      end
      if (held == 0 && sending) begin
        // hold off long enough for the pipe to fill and stall the input
        held = 1;
        @(posedge clk);
        hit_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    crossing_t exp_hit;
    if (!rst && hit_ch.valid && hit_ch.ready) begin
      if (pending_hits.size() == 0) begin
        $error("crossing item with no expectation waiting");
        n_errors++;
      end else begin
        exp_hit = pending_hits.pop_front();
        if (hit_ch.found !== exp_hit.found) begin
          $error("found: expected %0d, got %0d", exp_hit.found, hit_ch.found);
          n_errors++;
        end
        if (hit_ch.hit_x !== exp_hit.x) begin
          $error("hit_x: expected %0d, got %0d", exp_hit.x, hit_ch.hit_x);
          n_errors++;
        end
        if (hit_ch.hit_y !== exp_hit.y) begin
          $error("hit_y: expected %0d, got %0d", exp_hit.y, hit_ch.hit_y);
          n_errors++;
        end
      end
    end
  end

  // watchdog on cycles in which neither channel moves an item
  always @(posedge clk) begin
    if (rst || (seg_ch.valid && seg_ch.ready) || (hit_ch.valid && hit_ch.ready)) begin
      idle_cnt <= 0;
    end else begin
      idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= IDLE_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule

>>> files.f
rtl/core/scx_pkg.sv
rtl/core/scx_if.sv
rtl/core/scx_mul.sv
rtl/core/scx_div.sv
rtl/core/segment_circle_intersection.sv
test/tb_segment_circle_intersection.sv
